### rtl/core/c3v_pkg.sv
// Package for the 3x3 valid-region convolution block.
// Holds widths, register indexes, reset values and the pipeline tag type.
// No dependencies.
package c3v_pkg;

  localparam int PIX_BITS     = 8;
  localparam int GEOM_BITS    = 13;
  localparam int KROW_BITS    = 24;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int WIN          = 3;

  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_MAX_ROWS    = 4096;
  localparam int DEF_COEFF_BITS  = 8;

  localparam logic [PIX_BITS-1:0] PIXEL_MAX = 8'd255;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LINES = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KROW_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KROW_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KROW_BOTTOM = 3'd4;

  localparam logic [GEOM_BITS-1:0] RST_LINE_WIDTH  = 13'd640;
  localparam logic [GEOM_BITS-1:0] RST_FRAME_LINES = 13'd480;
  localparam logic [KROW_BITS-1:0] RST_KROW_TOP    = 24'd0;
  localparam logic [KROW_BITS-1:0] RST_KROW_MIDDLE = 24'd256;
  localparam logic [KROW_BITS-1:0] RST_KROW_BOTTOM = 24'd0;

  typedef struct packed {
    logic valid;
    logic last;
  } beat_tag_t;

endpackage

### rtl/core/conv3x3_valid_saturating.sv
// 3x3 convolution over the valid region of a raster frame, sums clamped at 255.
// Pipeline: an accepted pixel passes the registered store read, the products, the
// column sums and the clamp into the output register before out_tvalid rises.
// Throughput: one pixel per cycle unless the output is held; each line store takes
// one read and one write a cycle and the product/add path is fully pipelined. A held
// output stalls the input in the same cycle once the four pipeline stages are full.
// Reset: counters, pipeline valids and configuration registers go to reset values;
// line stores are not cleared (an entry is written before it can reach a result).
module conv3x3_valid_saturating import c3v_pkg::*; #(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int COEFF_BITS  = DEF_COEFF_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] pixel_in
  // output stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,  // [7:0] pixel_out
  output logic                     out_tlast   // frame_done
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int GEW = GEOM_BITS + 1;
  localparam int PW  = PIX_BITS + COEFF_BITS;
  localparam logic [GEW-1:0] MAXC = GEW'(MAX_COLUMNS);
  localparam logic [GEW-1:0] MAXR = GEW'(MAX_ROWS);
  localparam logic [GEW-1:0] MING = GEW'(3);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [GEOM_BITS-1:0]           line_width_r;
  logic [GEOM_BITS-1:0]           frame_lines_r;
  logic [WIN-1:0][KROW_BITS-1:0]  krow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r  <= RST_LINE_WIDTH;
      frame_lines_r <= RST_FRAME_LINES;
      krow_r[0]     <= RST_KROW_TOP;
      krow_r[1]     <= RST_KROW_MIDDLE;
      krow_r[2]     <= RST_KROW_BOTTOM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH:  line_width_r  <= cfg_data[GEOM_BITS-1:0];
        REG_FRAME_LINES: frame_lines_r <= cfg_data[GEOM_BITS-1:0];
        REG_KROW_TOP:    krow_r[0]     <= cfg_data[KROW_BITS-1:0];
        REG_KROW_MIDDLE: krow_r[1]     <= cfg_data[KROW_BITS-1:0];
        REG_KROW_BOTTOM: krow_r[2]     <= cfg_data[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturate geometry to 3..MAX so the counters always wrap inside the stores.
  logic [GEW-1:0] lw_ext, fl_ext, width_eff, lines_eff;

  always_comb begin
    lw_ext = GEW'(line_width_r);
    fl_ext = GEW'(frame_lines_r);
    if (lw_ext < MING)      width_eff = MING;
    else if (lw_ext > MAXC) width_eff = MAXC;
    else                    width_eff = lw_ext;
    if (fl_ext < MING)      lines_eff = MING;
    else if (fl_ext > MAXR) lines_eff = MAXR;
    else                    lines_eff = fl_ext;
  end

  // Coefficient (row r, window column c) sits at bits c*COEFF_BITS of row r;
  // bits above the register read as zero.
  logic [WIN-1:0][WIN-1:0][COEFF_BITS-1:0] coeff;  // [window col][row]

  for (genvar r = 0; r < WIN; r++) begin : g_coeff_row
    logic [2*KROW_BITS-1:0] krow_ext;
    assign krow_ext = {{KROW_BITS{1'b0}}, krow_r[r]};
    for (genvar c = 0; c < WIN; c++) begin : g_coeff_col
      assign coeff[c][r] = krow_ext[c*COEFF_BITS +: COEFF_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: position counters, accept and issue line store read
  // ---------------------------------------------------------------------------
  logic          in_fire;
  logic          ready2;
  logic          sum_ready;
  logic          fire1;
  logic          v1_r, v1_nxt;
  logic          v2_r, v2_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          last_col, last_row;
  logic          emit0, done0;

  assign ready2    = !v2_r || sum_ready;
  assign fire1     = v1_r && ready2;
  assign in_tready = !v1_r || ready2;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    last_col = (GEW'(col_r) + GEW'(1)) >= width_eff;
    last_row = (GEW'(row_r) + GEW'(1)) >= lines_eff;
    emit0    = (row_r >= RW'(2)) && (col_r >= CW'(2));
    done0    = last_col && last_row;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel and store read data; write back and shift window on advance
  // ---------------------------------------------------------------------------
  logic [PIX_BITS-1:0] pix1_r;
  logic [CW-1:0]       addr1_r;
  logic                emit1_r, done1_r;
  logic [PIX_BITS-1:0] rd_upper, rd_lower;

  assign v1_nxt = in_fire || (v1_r && !fire1);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix1_r  <= in_tdata[PIX_BITS-1:0];
      addr1_r <= col_r;
      emit1_r <= emit0;
      done1_r <= done0;
    end
  end

  c3v_line_buffer #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_lbuf (
    .clk      (clk),
    .rd_en    (in_fire),
    .rd_addr  (col_r),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower),
    .wr_en    (fire1),
    .wr_addr  (addr1_r),
    .wr_upper (rd_lower),
    .wr_lower (pix1_r)
  );

  // Chain of window cells: cell 0 takes the fresh column (newest window
  // column), each later cell takes its neighbor's column on the same beat.
  logic [WIN:0][WIN-1:0][PIX_BITS-1:0] col_chain;
  logic [WIN-1:0][WIN-1:0][PW-1:0]     prod;

  assign col_chain[0] = {pix1_r, rd_lower, rd_upper};

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    c3v_cell #(
      .COEFF_BITS (COEFF_BITS),
      .PW         (PW)
    ) u_cell (
      .clk      (clk),
      .shift_en (fire1),
      .col_in   (col_chain[k]),
      .coeff    (coeff[WIN-1-k]),
      .col_q    (col_chain[k+1]),
      .prod_q   (prod[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 2: products held in the cells; tag tracks whether they form a result
  // ---------------------------------------------------------------------------
  logic      done2_r;
  beat_tag_t tag2;

  assign v2_nxt = ready2 ? (fire1 && emit1_r) : v2_r;

  always_ff @(posedge clk) begin
    if (ready2) begin
      done2_r <= done1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
    end
  end

  assign tag2.valid = v2_r;
  assign tag2.last  = done2_r;

  // ---------------------------------------------------------------------------
  // Stages 3 and 4: column sums, total, clamp, output register
  // ---------------------------------------------------------------------------
  c3v_sum #(
    .COEFF_BITS (COEFF_BITS),
    .PW         (PW)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (tag2),
    .prod      (prod),
    .in_ready  (sum_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted beat always lands in stage 1
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v1_r)
    else $error("accepted beat did not reach stage 1");

  // a stalled stage-1 beat keeps its store address
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !ready2) |=> (v1_r && $stable(addr1_r)))
    else $error("stage 1 beat lost or changed while stalled");

  // the last column of a line wraps the column counter
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_col) |=> (col_r == '0))
    else $error("column counter did not wrap at end of line");

endmodule

### rtl/core/c3v_line_buffer.sv
// Two line stores holding the rows one and two above the current pixel.
// One registered read and one write per cycle on each store. Uses c3v_pkg.
module c3v_line_buffer import c3v_pkg::*; #(
  parameter int DEPTH = DEF_MAX_COLUMNS,
  parameter int AW    = $clog2(DEF_MAX_COLUMNS)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [PIX_BITS-1:0] rd_upper,
  output logic [PIX_BITS-1:0] rd_lower,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [PIX_BITS-1:0] wr_upper,
  input  logic [PIX_BITS-1:0] wr_lower
);

  logic [PIX_BITS-1:0] mem_upper_r [DEPTH];
  logic [PIX_BITS-1:0] mem_lower_r [DEPTH];
  logic [PIX_BITS-1:0] rd_upper_r;
  logic [PIX_BITS-1:0] rd_lower_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper_r <= mem_upper_r[rd_addr];
      rd_lower_r <= mem_lower_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper_r[wr_addr] <= wr_upper;
      mem_lower_r[wr_addr] <= wr_lower;
    end
  end

  assign rd_upper = rd_upper_r;
  assign rd_lower = rd_lower_r;

endmodule

### rtl/core/c3v_cell.sv
// One window column cell: holds three pixels, multiplies the incoming column
// by its three coefficients and hands its column on to the next cell. Uses c3v_pkg.
module c3v_cell import c3v_pkg::*; #(
  parameter int COEFF_BITS = DEF_COEFF_BITS,
  parameter int PW         = PIX_BITS + COEFF_BITS
) (
  input  logic                            clk,
  input  logic                            shift_en,
  input  logic [WIN-1:0][PIX_BITS-1:0]    col_in,
  input  logic [WIN-1:0][COEFF_BITS-1:0]  coeff,
  output logic [WIN-1:0][PIX_BITS-1:0]    col_q,
  output logic [WIN-1:0][PW-1:0]          prod_q
);

  logic [WIN-1:0][PIX_BITS-1:0] col_r;
  logic [WIN-1:0][PW-1:0]       prod_r;
  logic [WIN-1:0][PW-1:0]       prod_nxt;

  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      prod_nxt[r] = PW'(col_in[r]) * PW'(coeff[r]);
    end
  end

  // advance the column and its products together
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r  <= col_in;
      prod_r <= prod_nxt;
    end
  end

  assign col_q  = col_r;
  assign prod_q = prod_r;

endmodule

### rtl/core/c3v_sum.sv
// Adder and clamp stages: column sums, then the total clamped at 255 into the
// output register. Owns the output handshake. Uses c3v_pkg.
module c3v_sum import c3v_pkg::*; #(
  parameter int COEFF_BITS = DEF_COEFF_BITS,
  parameter int PW         = PIX_BITS + COEFF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  beat_tag_t                         in_tag,
  input  logic [WIN-1:0][WIN-1:0][PW-1:0]   prod,
  output logic                              in_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [PIX_BITS-1:0]               out_pixel,
  output logic                              out_last
);

  localparam int CSW = PW + 2;
  localparam int TSW = PW + 4;

  logic                          v3_r, v3_nxt;
  logic                          last3_r;
  logic [WIN-1:0][CSW-1:0]       colsum_r;
  logic [WIN-1:0][CSW-1:0]       colsum_nxt;
  logic                          v4_r, v4_nxt;
  logic                          last4_r;
  logic [PIX_BITS-1:0]           pix4_r;
  logic [PIX_BITS-1:0]           pix4_nxt;
  logic [TSW-1:0]                total;
  logic                          ready3;
  logic                          ready4;
  logic                          fire3;

  assign ready4   = !v4_r || out_ready;
  assign ready3   = !v3_r || ready4;
  assign fire3    = v3_r && ready4;
  assign in_ready = ready3;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      colsum_nxt[k] = CSW'(prod[k][0]) + CSW'(prod[k][1]) + CSW'(prod[k][2]);
    end
    total = TSW'(colsum_r[0]) + TSW'(colsum_r[1]) + TSW'(colsum_r[2]);
    pix4_nxt = (total > TSW'(PIXEL_MAX)) ? PIXEL_MAX : total[PIX_BITS-1:0];
  end

  always_comb begin
    v3_nxt = ready3 ? in_tag.valid : v3_r;
    v4_nxt = ready4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_tag.valid) begin
      colsum_r <= colsum_nxt;
      last3_r  <= in_tag.last;
    end
    if (fire3) begin
      pix4_r  <= pix4_nxt;
      last4_r <= last3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_pixel = pix4_r;
  assign out_last  = last4_r;

endmodule
